// ===== hw/rtl/pkcc_pkg.sv =====
// ---------------------------------------------------------------------------
// pkcc_pkg
// Shared constants, codes and the pipeline item type of the position keyed
// byte cipher.
// ---------------------------------------------------------------------------
package pkcc_pkg;

	localparam int PWD_DEPTH  = 128;
	localparam int PWD_IDX_W  = $clog2(PWD_DEPTH);
	localparam int POS_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 7;
	localparam int HDR_W      = 16;
	localparam int KEY_WORD_W = 64;
	localparam int KEY_WORDS  = 4;
	localparam int KEY_W      = KEY_WORD_W * KEY_WORDS;
	localparam int CFG_ADDR_W = 3;

	typedef enum logic [1:0] {
		ACT_ENCRYPT = 2'd0,
		ACT_DECRYPT = 2'd1,
		ACT_LOAD    = 2'd2
	} action_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_ENABLE   = 3'd0,
		CFG_PWD_LEN  = 3'd1,
		CFG_HDR_SIZE = 3'd2,
		CFG_KEY0     = 3'd3,
		CFG_KEY1     = 3'd4,
		CFG_KEY2     = 3'd5,
		CFG_KEY3     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              bypass;
	} item_t;

endpackage

// ===== hw/rtl/pkcc_pos_mod.sv =====
// ---------------------------------------------------------------------------
// pkcc_pos_mod
// Four-stage restoring remainder of position by password length, eight
// position bits per stage.
// ---------------------------------------------------------------------------
module pkcc_pos_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  pkcc_pkg::item_t              in_item,
	input  logic [pkcc_pkg::LEN_W-1:0]   len,
	output logic                         vld_s4,
	output pkcc_pkg::item_t              item_s4,
	output logic [pkcc_pkg::LEN_W-1:0]   pidx_s4
);

	function automatic logic [pkcc_pkg::LEN_W-1:0] mod_step8(
		input logic [pkcc_pkg::LEN_W-1:0] rem,
		input logic [7:0]                 bits,
		input logic [pkcc_pkg::LEN_W-1:0] div
	);
		logic [pkcc_pkg::LEN_W:0]   t;
		logic [pkcc_pkg::LEN_W-1:0] r;
		r = rem;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, div})
				t = t - {1'b0, div};
			r = t[pkcc_pkg::LEN_W-1:0];
		end
		return r;
	endfunction

	logic                       vld_s1, vld_s2, vld_s3;
	pkcc_pkg::item_t            item_s1, item_s2, item_s3;
	logic [pkcc_pkg::LEN_W-1:0] rem_s1, rem_s2, rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			rem_s1  <= mod_step8('0, in_item.pos[31:24], len);
			item_s2 <= item_s1;
			rem_s2  <= mod_step8(rem_s1, item_s1.pos[23:16], len);
			item_s3 <= item_s2;
			rem_s3  <= mod_step8(rem_s2, item_s2.pos[15:8], len);
			item_s4 <= item_s3;
			pidx_s4 <= mod_step8(rem_s3, item_s3.pos[7:0], len);
		end
	end

endmodule

// ===== hw/rtl/pkcc_pwd_mem.sv =====
// ---------------------------------------------------------------------------
// pkcc_pwd_mem
// Password table stage: loads write the table, cipher items read it, both
// in pipeline order.
// ---------------------------------------------------------------------------
module pkcc_pwd_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_s4,
	input  pkcc_pkg::item_t              item_s4,
	input  logic [pkcc_pkg::LEN_W-1:0]   pidx_s4,
	output logic                         vld_s5,
	output pkcc_pkg::item_t              item_s5,
	output logic [pkcc_pkg::BYTE_W-1:0]  pwd_s5
);

	logic [pkcc_pkg::BYTE_W-1:0] mem [pkcc_pkg::PWD_DEPTH];
	logic [pkcc_pkg::BYTE_W-1:0] rd_s5;
	logic                        oob_s5;
	logic                        wr;

	assign wr = en && vld_s4 && (item_s4.action == pkcc_pkg::ACT_LOAD) &&
		(item_s4.pos < 32'(pkcc_pkg::PWD_DEPTH));

	always_ff @(posedge clk) begin
		if (wr)
			mem[pkcc_pkg::PWD_IDX_W'(item_s4.pos)] <= item_s4.data;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_s5   <= mem[pkcc_pkg::PWD_IDX_W'(pidx_s4)];
			oob_s5  <= (32'(pidx_s4) >= 32'(pkcc_pkg::PWD_DEPTH));
			item_s5 <= item_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_s4;
	end

	assign pwd_s5 = oob_s5 ? '0 : rd_s5;

endmodule

// ===== hw/rtl/pkcc_xform.sv =====
// ---------------------------------------------------------------------------
// pkcc_xform
// Byte transform: encrypt or decrypt with key and password bytes, or pass.
// ---------------------------------------------------------------------------
module pkcc_xform (
	input  pkcc_pkg::item_t              item,
	input  logic [pkcc_pkg::BYTE_W-1:0]  pwd,
	input  logic [pkcc_pkg::KEY_W-1:0]   key,
	output logic [pkcc_pkg::BYTE_W-1:0]  data_out
);

	function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
		logic [15:0] w;
		w = {x, x} << n;
		return w[15:8];
	endfunction

	function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] n);
		logic [15:0] w;
		w = {x, x} >> n;
		return w[7:0];
	endfunction

	logic [7:0] k;
	logic [7:0] enc, dec;

	assign k = key[{item.pos[4:0], 3'b000} +: 8];

	always_comb begin
		enc = item.data ^ k;
		enc = rotl8(enc, pwd[2:0]);
		enc = enc ^ pwd;
		if (pwd[0])
			enc = rotl8(enc, 3'd2);
		if (k[0])
			enc = ~enc;

		dec = item.data;
		if (k[0])
			dec = ~dec;
		if (pwd[0])
			dec = rotr8(dec, 3'd2);
		dec = dec ^ pwd;
		dec = rotr8(dec, pwd[2:0]);
		dec = dec ^ k;
	end

	always_comb begin
		if (item.bypass)
			data_out = item.data;
		else if (item.action == pkcc_pkg::ACT_DECRYPT)
			data_out = dec;
		else
			data_out = enc;
	end

endmodule

// ===== hw/rtl/position_keyed_byte_cipher_core.sv =====
// ---------------------------------------------------------------------------
// position_keyed_byte_cipher_core
// Per-byte cipher keyed by file position, with password table and key.
// ---------------------------------------------------------------------------
// Takes one request per cycle while the output buffer is not full. Each accepted
// request passes down the pipe: four stages work out position modulo password
// length, one stage reads the password table, and the transform lands in a
// two-entry output buffer that feeds the master side. Password loads travel the
// same pipe and write the table in order with the reads; they and action 3
// give no result. Configuration must only be written while the pipe is empty.
module position_keyed_byte_cipher_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pkcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [pkcc_pkg::KEY_WORD_W-1:0]    cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [39:0]                        s_tdata,  // position[31:0], data_in[39:32]
	input  logic [1:0]                         s_tuser,  // action[1:0]
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,  // data_out[7:0]
	output logic                               m_tlast
);

	logic                                            enable_q;
	logic [pkcc_pkg::LEN_W-1:0]                      pwd_len_q;
	logic [pkcc_pkg::HDR_W-1:0]                      hdr_size_q;
	logic [pkcc_pkg::KEY_WORDS-1:0][pkcc_pkg::KEY_WORD_W-1:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			pwd_len_q  <= pkcc_pkg::LEN_W'(1);
			hdr_size_q <= '0;
			key_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pkcc_pkg::CFG_ENABLE:   enable_q   <= cfg_wdata[0];
				pkcc_pkg::CFG_PWD_LEN:  pwd_len_q  <= cfg_wdata[pkcc_pkg::LEN_W-1:0];
				pkcc_pkg::CFG_HDR_SIZE: hdr_size_q <= cfg_wdata[pkcc_pkg::HDR_W-1:0];
				pkcc_pkg::CFG_KEY0:     key_q[0]   <= cfg_wdata;
				pkcc_pkg::CFG_KEY1:     key_q[1]   <= cfg_wdata;
				pkcc_pkg::CFG_KEY2:     key_q[2]   <= cfg_wdata;
				pkcc_pkg::CFG_KEY3:     key_q[3]   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic                        en;
	logic [1:0]                  cnt_q;
	logic [pkcc_pkg::LEN_W-1:0]  len_eff;
	pkcc_pkg::item_t             in_item;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign len_eff  = (pwd_len_q == '0) ? pkcc_pkg::LEN_W'(1) : pwd_len_q;

	always_comb begin
		in_item.action = s_tuser;
		in_item.pos    = s_tdata[31:0];
		in_item.data   = s_tdata[39:32];
		in_item.last   = s_tlast;
		in_item.bypass = !enable_q || (s_tdata[31:0] < 32'(hdr_size_q));
	end

	logic                         vld_s4, vld_s5;
	pkcc_pkg::item_t              item_s4, item_s5;
	logic [pkcc_pkg::LEN_W-1:0]   pidx_s4;
	logic [pkcc_pkg::BYTE_W-1:0]  pwd_s5;
	logic [pkcc_pkg::BYTE_W-1:0]  xf_data;

	pkcc_pos_mod u_pos_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.in_item (in_item),
		.len     (len_eff),
		.vld_s4  (vld_s4),
		.item_s4 (item_s4),
		.pidx_s4 (pidx_s4)
	);

	pkcc_pwd_mem u_pwd_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s4  (vld_s4),
		.item_s4 (item_s4),
		.pidx_s4 (pidx_s4),
		.vld_s5  (vld_s5),
		.item_s5 (item_s5),
		.pwd_s5  (pwd_s5)
	);

	pkcc_xform u_xform (
		.item     (item_s5),
		.pwd      (pwd_s5),
		.key      (key_q),
		.data_out (xf_data)
	);

	// two-entry output buffer
	logic       push, pop;
	logic [8:0] head_q, skid_q;

	assign push = en && vld_s5 && ((item_s5.action == pkcc_pkg::ACT_ENCRYPT) ||
		(item_s5.action == pkcc_pkg::ACT_DECRYPT));
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
			head_q <= {item_s5.last, xf_data};
		else if (pop && cnt_q == 2'd2)
			head_q <= skid_q;
		if (push && cnt_q == 2'd1 && !pop)
			skid_q <= {item_s5.last, xf_data};
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = head_q[7:0];
	assign m_tlast  = head_q[8];

endmodule

// ===== hw/rtl/pkcc_checker.sv =====
// ---------------------------------------------------------------------------
// pkcc_checker
// Port-level checks of the cipher core's stream behavior.
// ---------------------------------------------------------------------------
module pkcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output request changed while stalled");

	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output buffer");

	a_pop_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready)
		else $error("input still stalled after output taken");

	a_output_from_open_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tready))
		else $error("output appeared while input was stalled");

endmodule

bind position_keyed_byte_cipher_core pkcc_checker u_pkcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
